@@ hdl/per_cpu_page_allocator_steal_defines.svh @@
// Assertion helpers used by the allocator controller.
`ifndef PER_CPU_PAGE_ALLOCATOR_STEAL_DEFINES_SVH
`define PER_CPU_PAGE_ALLOCATOR_STEAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCPA_AST_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCPA_AST_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pcpa_pkg.sv @@
package pcpa_pkg;

	localparam int NUM_CPUS  = 8;
	localparam int NUM_PAGES = 1024;

	localparam int CPU_W  = 3;
	localparam int PAGE_W = 10;
	localparam int LIM_W  = PAGE_W + 1;
	localparam int LEN_W  = $clog2(NUM_PAGES) + 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic REG_FIRST_PAGE = 1'b0;
	localparam logic REG_PAGE_LIMIT = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [CPU_W-1:0]  cpu;
		logic [PAGE_W-1:0] page_in;
	} in_word_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_out;
		logic [1:0]        status;
		logic              stolen;
		logic [CPU_W-1:0]  victim_cpu;
	} out_word_t;

	// One entry of the link memory: next page of a list node.
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] next;
	} link_t;

	// Write into the head table.
	typedef struct packed {
		logic              en;
		logic [CPU_W-1:0]  idx;
		logic [PAGE_W-1:0] page;
		logic              nonempty;
	} head_wr_t;

endpackage

@@ hdl/pcpa_link_ram.sv @@
module pcpa_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/pcpa_heads.sv @@
module pcpa_heads (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcpa_pkg::head_wr_t             hw,
	input  logic [pcpa_pkg::CPU_W-1:0]     rd_idx,
	output logic [pcpa_pkg::PAGE_W-1:0]    rd_page,
	output logic                           rd_nonempty,
	output logic                           victim_found,
	output logic [pcpa_pkg::CPU_W-1:0]     victim_idx
);

	localparam int CW = pcpa_pkg::CPU_W;
	localparam int NC = pcpa_pkg::NUM_CPUS;

	logic [pcpa_pkg::PAGE_W-1:0] head_q [NC];
	logic [NC-1:0]               nonempty_q;
	logic [CW:0]                 pick;

	// First non-empty list after the requester, wrapping around.
	function automatic logic [CW:0] find_victim(input logic [NC-1:0] ne,
		input logic [CW-1:0] c);
		logic [CW:0] res;
		logic [CW:0] v;
		res = '0;
		for (int i = NC - 1; i >= 1; i--) begin
			v = (CW+1)'(c) + (CW+1)'(i);
			if (v >= (CW+1)'(NC)) begin
				v = v - (CW+1)'(NC);
			end
			if (ne[v[CW-1:0]]) begin
				res = {1'b1, v[CW-1:0]};
			end
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				head_q[i] <= '0;
			end
			nonempty_q <= '0;
		end else if (hw.en) begin
			head_q[hw.idx]     <= hw.page;
			nonempty_q[hw.idx] <= hw.nonempty;
		end
	end

	assign rd_page      = head_q[rd_idx];
	assign rd_nonempty  = nonempty_q[rd_idx];
	assign pick         = find_victim(nonempty_q, rd_idx);
	assign victim_found = pick[CW];
	assign victim_idx   = pick[CW-1:0];

endmodule

@@ hdl/pcpa_ctrl.sv @@
`include "per_cpu_page_allocator_steal_defines.svh"

module pcpa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pcpa_pkg::in_word_t            in_word,
	input  logic [pcpa_pkg::PAGE_W-1:0]   first_page,
	input  logic [pcpa_pkg::LIM_W-1:0]    page_limit,
	output logic                          res_valid,
	input  logic                          res_take,
	output pcpa_pkg::out_word_t           res_word,
	output logic                          ram_we,
	output logic [pcpa_pkg::PAGE_W-1:0]   ram_waddr,
	output pcpa_pkg::link_t               ram_wdata,
	output logic [pcpa_pkg::PAGE_W-1:0]   ram_raddr,
	input  pcpa_pkg::link_t               ram_rdata,
	output pcpa_pkg::head_wr_t            hw,
	output logic [pcpa_pkg::CPU_W-1:0]    head_idx,
	input  logic [pcpa_pkg::PAGE_W-1:0]   head_page,
	input  logic                          head_nonempty,
	input  logic                          victim_found,
	input  logic [pcpa_pkg::CPU_W-1:0]    victim_idx
);

	localparam int CW = pcpa_pkg::CPU_W;
	localparam int PW = pcpa_pkg::PAGE_W;
	localparam int LW = pcpa_pkg::LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP,
		ST_STEAL,
		ST_WALK,
		ST_SEEK,
		ST_GIVE,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic                 cmd_q;
	logic [CW-1:0]        cpu_q;
	logic [PW-1:0]        page_q;
	logic [CW-1:0]        vic_q;
	logic [PW-1:0]        head_q;
	logic [PW-1:0]        slow_q;
	logic [LW-1:0]        len_q;
	logic [LW-1:0]        cnt_q;
	logic                 hvalid_q;
	logic [PW-1:0]        hnext_q;
	pcpa_pkg::out_word_t  res_q;

	logic                 cpu_ok;
	logic                 page_ok;
	logic                 walk_more;
	logic [LW:0]          len_p1;
	logic [LW-1:0]        half;
	logic [PW-1:0]        link_page;

	assign cpu_ok  = (CW+1)'(cpu_q) < (CW+1)'(pcpa_pkg::NUM_CPUS);
	assign page_ok = (page_q >= first_page)
		&& (pcpa_pkg::LIM_W'(page_q) < page_limit)
		&& (LW'(page_q) < LW'(pcpa_pkg::NUM_PAGES));

	// Walk on while the node links on and the count is below the cap.
	assign walk_more = ram_rdata.valid && (len_q < LW'(pcpa_pkg::NUM_PAGES));
	assign len_p1    = {1'b0, len_q} + (LW+1)'(1);
	assign half      = len_p1[LW:1];
	assign link_page = ram_rdata.valid ? ram_rdata.next : '0;

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_word  = res_q;
	assign head_idx  = (state_q == ST_STEAL) ? vic_q : cpu_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = page_q;
		ram_wdata = '0;
		ram_raddr = '0;
		hw        = '0;
		unique case (state_q)
			ST_DECODE: begin
				if (cmd_q == pcpa_pkg::CMD_FREE) begin
					if (cpu_ok && page_ok) begin
						ram_we    = 1'b1;
						ram_wdata = '{valid: head_nonempty, next: head_page};
						hw        = '{en: 1'b1, idx: cpu_q, page: page_q, nonempty: 1'b1};
					end
				end else if (cpu_ok && head_nonempty) begin
					ram_raddr = head_page;
				end
			end
			ST_STEAL: begin
				ram_raddr = head_page;
			end
			ST_WALK: begin
				ram_raddr = walk_more ? ram_rdata.next : head_q;
			end
			ST_SEEK: begin
				if (cnt_q == '0) begin
					// cut the list after the split node; victim keeps the tail
					ram_we    = 1'b1;
					ram_waddr = slow_q;
					ram_wdata = '{valid: 1'b0, next: ram_rdata.next};
					hw        = '{en: 1'b1, idx: vic_q, page: link_page,
						nonempty: ram_rdata.valid};
				end else begin
					ram_raddr = ram_rdata.next;
				end
			end
			ST_POP: begin
				hw = '{en: 1'b1, idx: cpu_q, page: link_page, nonempty: ram_rdata.valid};
			end
			ST_GIVE: begin
				if (slow_q == head_q) begin
					hw = '{en: 1'b1, idx: cpu_q, page: '0, nonempty: 1'b0};
				end else begin
					hw = '{en: 1'b1, idx: cpu_q, page: hvalid_q ? hnext_q : '0,
						nonempty: hvalid_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_word.cmd;
						cpu_q   <= in_word.cpu;
						page_q  <= in_word.page_in;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (cmd_q == pcpa_pkg::CMD_FREE) begin
						res_q   <= '{page_out: '0,
							status: (cpu_ok && page_ok) ? pcpa_pkg::STAT_OK
								: pcpa_pkg::STAT_RANGE,
							stolen: 1'b0, victim_cpu: '0};
						state_q <= ST_DONE;
					end else if (!cpu_ok) begin
						res_q   <= '{page_out: '0, status: pcpa_pkg::STAT_EMPTY,
							stolen: 1'b0, victim_cpu: '0};
						state_q <= ST_DONE;
					end else if (head_nonempty) begin
						head_q  <= head_page;
						state_q <= ST_POP;
					end else if (victim_found) begin
						vic_q   <= victim_idx;
						state_q <= ST_STEAL;
					end else begin
						res_q   <= '{page_out: '0, status: pcpa_pkg::STAT_EMPTY,
							stolen: 1'b0, victim_cpu: '0};
						state_q <= ST_DONE;
					end
				end
				ST_POP: begin
					res_q   <= '{page_out: head_q, status: pcpa_pkg::STAT_OK,
						stolen: 1'b0, victim_cpu: '0};
					state_q <= ST_DONE;
				end
				ST_STEAL: begin
					head_q  <= head_page;
					len_q   <= LW'(1);
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (len_q == LW'(1)) begin
						hvalid_q <= ram_rdata.valid;
						hnext_q  <= ram_rdata.next;
					end
					if (walk_more) begin
						len_q <= len_q + LW'(1);
					end else begin
						cnt_q   <= half - LW'(1);
						slow_q  <= head_q;
						state_q <= ST_SEEK;
					end
				end
				ST_SEEK: begin
					if (cnt_q == '0) begin
						state_q <= ST_GIVE;
					end else begin
						slow_q <= ram_rdata.next;
						cnt_q  <= cnt_q - LW'(1);
					end
				end
				ST_GIVE: begin
					res_q   <= '{page_out: head_q, status: pcpa_pkg::STAT_OK,
						stolen: 1'b1, victim_cpu: vic_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PCPA_AST_NXT(a_accept_decodes, clk, arst_n, in_valid && !in_stall, state_q == ST_DECODE, "accepted word did not reach decode")
	`PCPA_AST_IMP(a_walk_len, clk, arst_n, state_q == ST_WALK, (len_q != '0) && (len_q <= LW'(pcpa_pkg::NUM_PAGES)), "walk length out of bounds")
	`PCPA_AST_IMP(a_seek_cnt, clk, arst_n, state_q == ST_SEEK, cnt_q < len_q, "split count not below list length")
	`PCPA_AST_IMP(a_idle_quiet, clk, arst_n, state_q == ST_IDLE, !hw.en && !ram_we, "state written while idle")

endmodule

@@ hdl/per_cpu_page_allocator_steal.sv @@
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    in_word  (cmd, cpu, page_in)
// out      out  out_valid / out_stall  out_word (page_out, status, stolen, victim_cpu)
// cfg      in   APB psel/penable       first_page @ 0x0, page_limit @ 0x4
//
// One word at a time. A steal walks the victim's list through the one-read-a-cycle
// link memory: it counts the list, then seeks to the split node.
// Reset clears every list to empty; link memory needs no clearing pass.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and its result holds inside until the register frees up.
module per_cpu_page_allocator_steal (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pcpa_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pcpa_pkg::out_word_t  out_word,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int PW = pcpa_pkg::PAGE_W;
	localparam int LW = pcpa_pkg::LIM_W;

	// configuration registers
	logic [PW-1:0] first_page_q;
	logic [LW-1:0] page_limit_q;
	logic          cfg_wr;

	// output register
	logic                 out_valid_q;
	pcpa_pkg::out_word_t  out_word_q;
	logic                 res_valid;
	logic                 res_take;
	pcpa_pkg::out_word_t  res_word;

	// link memory port
	logic                 ram_we;
	logic [PW-1:0]        ram_waddr;
	pcpa_pkg::link_t      ram_wdata;
	logic [PW-1:0]        ram_raddr;
	pcpa_pkg::link_t      ram_rdata;

	// head table port
	pcpa_pkg::head_wr_t            hw;
	logic [pcpa_pkg::CPU_W-1:0]    head_idx;
	logic [PW-1:0]                 head_page;
	logic                          head_nonempty;
	logic                          victim_found;
	logic [pcpa_pkg::CPU_W-1:0]    victim_idx;

	// APB: zero wait states; word address picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == pcpa_pkg::REG_PAGE_LIMIT)
		? {{(32 - LW){1'b0}}, page_limit_q}
		: {{(32 - PW){1'b0}}, first_page_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
			page_limit_q <= LW'(pcpa_pkg::NUM_PAGES);
		end else if (cfg_wr) begin
			if (paddr[2] == pcpa_pkg::REG_FIRST_PAGE) begin
				first_page_q <= pwdata[PW-1:0];
			end else begin
				page_limit_q <= pwdata[LW-1:0];
			end
		end
	end

	// Load a finished result when the output register is empty or draining.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_word_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	pcpa_link_ram #(
		.DEPTH(pcpa_pkg::NUM_PAGES),
		.WIDTH($bits(pcpa_pkg::link_t))
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pcpa_heads u_heads (
		.clk         (clk),
		.arst_n      (arst_n),
		.hw          (hw),
		.rd_idx      (head_idx),
		.rd_page     (head_page),
		.rd_nonempty (head_nonempty),
		.victim_found(victim_found),
		.victim_idx  (victim_idx)
	);

	pcpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_word      (in_word),
		.first_page   (first_page_q),
		.page_limit   (page_limit_q),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res_word     (res_word),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.hw           (hw),
		.head_idx     (head_idx),
		.head_page    (head_page),
		.head_nonempty(head_nonempty),
		.victim_found (victim_found),
		.victim_idx   (victim_idx)
	);

endmodule

@@ tb/per_cpu_page_allocator_steal_tb.sv @@
`timescale 1ns / 1ps

module per_cpu_page_allocator_steal_tb;

	// Generous ceiling: every word a capped steal walk plus the longest gaps, several times over
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	// Long receiver hold-off, enough for the block to fill up and stall its input
	localparam int HOLD_CYCLES = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	pcpa_pkg::in_word_t   in_word;
	logic                 out_valid;
	logic                 out_stall;
	pcpa_pkg::out_word_t  out_word;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	int unsigned cycle_count = 0;
	bit          sender_quiet;

	// Shadow of the allocator: per-CPU list heads plus the link memory, and a queue of
	// results still owed by the block.
	class allocator_scoreboard;
		bit [pcpa_pkg::PAGE_W-1:0] next_page [pcpa_pkg::NUM_PAGES];
		bit                        has_next [pcpa_pkg::NUM_PAGES];
		bit [pcpa_pkg::PAGE_W-1:0] head_of [pcpa_pkg::NUM_CPUS];
		bit                        holds [pcpa_pkg::NUM_CPUS];
		// Rough record of pages sitting on some list, used only to shape stimulus
		bit                        on_list [pcpa_pkg::NUM_PAGES];
		int                        pages_held;
		bit [pcpa_pkg::PAGE_W-1:0] first_page;
		bit [pcpa_pkg::LIM_W-1:0]  page_limit;
		pcpa_pkg::out_word_t       awaited [$];
		int                        errors;

		function new();
			first_page = '0;
			page_limit = pcpa_pkg::LIM_W'(pcpa_pkg::NUM_PAGES);
			pages_held = 0;
			errors = 0;
		endfunction

		function void set_register(logic idx, int unsigned value);
			if (idx == pcpa_pkg::REG_FIRST_PAGE) begin
				first_page = value[pcpa_pkg::PAGE_W-1:0];
			end else begin
				page_limit = value[pcpa_pkg::LIM_W-1:0];
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Apply one accepted word to the shadow state and queue the result it owes.
		function void note_request(pcpa_pkg::in_word_t w);
			pcpa_pkg::out_word_t       want;
			int unsigned               len;
			int unsigned               k;
			int                        i;
			int                        v;
			bit [pcpa_pkg::PAGE_W-1:0] h;
			bit [pcpa_pkg::PAGE_W-1:0] p;
			bit [pcpa_pkg::PAGE_W-1:0] slow;
			want = '0;
			if (w.cmd == pcpa_pkg::CMD_FREE) begin
				if (w.page_in < first_page || w.page_in >= page_limit) begin
					want.status = pcpa_pkg::STAT_RANGE;
				end else begin
					// Push onto the requester's list
					next_page[w.page_in] = head_of[w.cpu];
					has_next[w.page_in] = holds[w.cpu];
					head_of[w.cpu] = w.page_in;
					holds[w.cpu] = 1'b1;
					if (!on_list[w.page_in]) begin
						on_list[w.page_in] = 1'b1;
						pages_held++;
					end
				end
			end else begin
				if (holds[w.cpu]) begin
					// Pop own head
					h = head_of[w.cpu];
					want.page_out = h;
					if (has_next[h]) begin
						head_of[w.cpu] = next_page[h];
					end else begin
						head_of[w.cpu] = '0;
						holds[w.cpu] = 1'b0;
					end
				end else begin
					want.status = pcpa_pkg::STAT_EMPTY;
					v = w.cpu;
					for (i = 1; i < pcpa_pkg::NUM_CPUS; i++) begin
						v = (v + 1 == pcpa_pkg::NUM_CPUS) ? 0 : v + 1;
						if (holds[v]) begin
							// Count the victim's list, capped so a looped list still ends
							h = head_of[v];
							len = 1;
							p = h;
							while (len < pcpa_pkg::NUM_PAGES && has_next[p]) begin
								p = next_page[p];
								len++;
							end
							// Walk to the last node of the front half and cut there
							k = (len + 1) / 2;
							slow = h;
							for (int unsigned j = 1; j < k; j++) begin
								slow = next_page[slow];
							end
							if (has_next[slow]) begin
								head_of[v] = next_page[slow];
								holds[v] = 1'b1;
							end else begin
								head_of[v] = '0;
								holds[v] = 1'b0;
							end
							has_next[slow] = 1'b0;
							// Requester hands out the head and keeps the rest of the front half
							if (has_next[h]) begin
								head_of[w.cpu] = next_page[h];
								holds[w.cpu] = 1'b1;
							end else begin
								head_of[w.cpu] = '0;
								holds[w.cpu] = 1'b0;
							end
							want.page_out = h;
							want.status = pcpa_pkg::STAT_OK;
							want.stolen = 1'b1;
							want.victim_cpu = v[pcpa_pkg::CPU_W-1:0];
							break;
						end
					end
				end
				if (want.status == pcpa_pkg::STAT_OK && on_list[want.page_out]) begin
					on_list[want.page_out] = 1'b0;
					pages_held--;
				end
			end
			awaited.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(pcpa_pkg::out_word_t got);
			pcpa_pkg::out_word_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited: expected none, got page %0d status %0d",
					$time, got.page_out, got.status);
				return;
			end
			want = awaited.pop_front();
			compare_field("page_out", 32'(want.page_out), 32'(got.page_out));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("stolen", 32'(want.stolen), 32'(got.stolen));
			compare_field("victim_cpu", 32'(want.victim_cpu), 32'(got.victim_cpu));
		endfunction
	endclass

	allocator_scoreboard sb;

	per_cpu_page_allocator_steal uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic pcpa_pkg::in_word_t request(logic cmd, int cpu, int page);
		pcpa_pkg::in_word_t r;
		r.cmd = cmd;
		r.cpu = cpu[pcpa_pkg::CPU_W-1:0];
		r.page_in = page[pcpa_pkg::PAGE_W-1:0];
		return r;
	endfunction

	// Offer one word after a random gap; hold it until the block takes it.
	// Keep valid high across back-to-back words so it is never dropped and raised in one step.
	task automatic send_word(pcpa_pkg::in_word_t w);
		int gap;
		if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
		gap = sender_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		sb.note_request(w);
	endtask

	// APB write: setup phase, access phase until pready, then an idle phase
	task automatic write_register(logic idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// Drop valid and wait for every owed result, then idle for the extra time asked
	task automatic settle(int extra);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Mostly well-formed traffic: frees of pages not already on a list, within the
	// allowed window, balanced against allocs so lists stay short. One word in ten is
	// noise: any command, any page, which brings range errors and double frees.
	task automatic run_random(int count);
		pcpa_pkg::in_word_t w;
		int                 tries;
		int unsigned        p;
		int unsigned        r;
		bit                 found;
		repeat (count) begin
			r = $urandom_range(0, pcpa_pkg::NUM_CPUS - 1);
			w.cpu = r[pcpa_pkg::CPU_W-1:0];
			r = $urandom_range(0, pcpa_pkg::NUM_PAGES - 1);
			w.page_in = r[pcpa_pkg::PAGE_W-1:0];
			if ($urandom_range(0, 9) == 0) begin
				w.cmd = $urandom_range(0, 1) ? pcpa_pkg::CMD_FREE : pcpa_pkg::CMD_ALLOC;
			end else if (sb.pages_held > 24 ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 1) == 0)) begin
				w.cmd = pcpa_pkg::CMD_ALLOC;
			end else begin
				found = 1'b0;
				if (sb.first_page < sb.page_limit) begin
					for (tries = 0; tries < 8 && !found; tries++) begin
						p = $urandom_range(sb.page_limit - 1, sb.first_page);
						if (!sb.on_list[p]) found = 1'b1;
					end
				end
				if (found) begin
					w.cmd = pcpa_pkg::CMD_FREE;
					w.page_in = p[pcpa_pkg::PAGE_W-1:0];
				end else begin
					w.cmd = pcpa_pkg::CMD_ALLOC;
				end
			end
			send_word(w);
		end
	endtask

	// Receiver: random stall before each word, quiet stretches, and two long hold-offs
	// while the sender keeps offering.
	initial begin
		int wait_cycles;
		int taken;
		bit quiet;
		out_stall = 1'b0;
		taken = 0;
		quiet = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) quiet = !quiet;
			if (taken == 120 || taken == 400) begin
				wait_cycles = HOLD_CYCLES;
			end else begin
				wait_cycles = quiet ? 0 : $urandom_range(0, 17);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_word);
			taken++;
		end
	end

	initial begin
		sb = new();
		sender_quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window: every page may be freed.
		// Alloc with every list empty
		send_word(request(pcpa_pkg::CMD_ALLOC, 0, 0));
		// Lowest and highest page, lowest and highest CPU, then pop them back
		send_word(request(pcpa_pkg::CMD_FREE, 0, 0));
		send_word(request(pcpa_pkg::CMD_FREE, pcpa_pkg::NUM_CPUS - 1,
			pcpa_pkg::NUM_PAGES - 1));
		send_word(request(pcpa_pkg::CMD_ALLOC, pcpa_pkg::NUM_CPUS - 1, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 0, 0));
		// Build a five-page list on CPU 3, then steal its front three from CPU 2
		for (int pg = 10; pg < 15; pg++) send_word(request(pcpa_pkg::CMD_FREE, 3, pg));
		send_word(request(pcpa_pkg::CMD_ALLOC, 2, 0));
		// CPU 5 scans past the top and wraps to find CPU 2
		send_word(request(pcpa_pkg::CMD_ALLOC, 5, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 3, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 2, 0));
		// Double free makes a self-loop; pop follows it, steal walk hits the cap
		send_word(request(pcpa_pkg::CMD_FREE, 6, 20));
		send_word(request(pcpa_pkg::CMD_FREE, 6, 20));
		send_word(request(pcpa_pkg::CMD_ALLOC, 6, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 4, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 6, 0));
		// Last CPU wraps to CPU 3 for its last page
		send_word(request(pcpa_pkg::CMD_ALLOC, pcpa_pkg::NUM_CPUS - 1, 0));
		run_random(150);
		settle(4);

		// Narrow window: edges of the range and a far-off page
		write_register(pcpa_pkg::REG_FIRST_PAGE, 100);
		write_register(pcpa_pkg::REG_PAGE_LIMIT, 200);
		send_word(request(pcpa_pkg::CMD_FREE, 1, 99));
		send_word(request(pcpa_pkg::CMD_FREE, 1, 200));
		send_word(request(pcpa_pkg::CMD_FREE, 1, 100));
		send_word(request(pcpa_pkg::CMD_FREE, 1, 199));
		send_word(request(pcpa_pkg::CMD_FREE, 1, pcpa_pkg::NUM_PAGES - 1));
		send_word(request(pcpa_pkg::CMD_ALLOC, 1, 0));
		send_word(request(pcpa_pkg::CMD_ALLOC, 1, 0));
		run_random(110);
		settle(4);

		// Only the top page is freeable
		write_register(pcpa_pkg::REG_FIRST_PAGE, pcpa_pkg::NUM_PAGES - 1);
		write_register(pcpa_pkg::REG_PAGE_LIMIT, pcpa_pkg::NUM_PAGES);
		run_random(70);
		settle(4);

		// Only page zero is freeable
		write_register(pcpa_pkg::REG_FIRST_PAGE, 0);
		write_register(pcpa_pkg::REG_PAGE_LIMIT, 1);
		run_random(70);
		settle(4);

		// Empty window: every free is rejected, allocs drain what is left
		write_register(pcpa_pkg::REG_FIRST_PAGE, pcpa_pkg::NUM_PAGES - 1);
		run_random(40);
		settle(4);

		// Back to the full window
		write_register(pcpa_pkg::REG_FIRST_PAGE, 0);
		write_register(pcpa_pkg::REG_PAGE_LIMIT, pcpa_pkg::NUM_PAGES);
		run_random(180);

		// Drain, then leave room for any stray result to show up
		settle(64);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
